>>> hw/rtl/pfl_pkg.sv
`timescale 1ns / 1ps

package pfl_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W = 10;
  localparam int DISP_WIDTH_DEF = 128;
  localparam int DISP_HEIGHT_DEF = 64;
  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  typedef enum logic [2:0] {
    FUNC_HLINE = 3'd0,
    FUNC_VLINE = 3'd1,
    FUNC_RECT  = 3'd2,
    FUNC_FILL  = 3'd3,
    FUNC_READ  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_SET    = 2'd1,
    MODE_TOGGLE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic load_draw;
    logic load_sweep;
    logic rd_draw;
    logic wr_back;
    logic sweep_wr;
    logic rd_host;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic draw_last;
    logic sweep_last;
  } stat_t;

endpackage

>>> hw/rtl/pfl_ctrl.sv
`timescale 1ns / 1ps

module pfl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2:0]     func,
  input  logic [1:0]     color_mode,
  input  pfl_pkg::stat_t stat,
  output pfl_pkg::ctrl_t ctrl,
  output logic           busy,
  output logic           strobe
);
  import pfl_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_RMW_RD = 7'b0000100,
    ST_RMW_WR = 7'b0001000,
    ST_SWEEP  = 7'b0010000,
    ST_RD_OUT = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign strobe = (state == ST_RD_OUT);

  always_comb begin
    state_next = state;
    ctrl = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (func)
            FUNC_HLINE, FUNC_VLINE, FUNC_RECT: begin
              if (color_mode != MODE_NONE) begin
                ctrl.load_draw = 1'b1;
                state_next = ST_CHECK;
              end
            end
            FUNC_FILL: begin
              if (color_mode == MODE_CLEAR || color_mode == MODE_SET) begin
                ctrl.load_sweep = 1'b1;
                state_next = ST_SWEEP;
              end
            end
            FUNC_READ: begin
              ctrl.rd_host = 1'b1;
              state_next = ST_RD_OUT;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CHECK: begin
        state_next = stat.empty ? ST_IDLE : ST_RMW_RD;
      end
      ST_RMW_RD: begin
        ctrl.rd_draw = 1'b1;
        state_next = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        ctrl.wr_back = 1'b1;
        state_next = stat.draw_last ? ST_IDLE : ST_RMW_RD;
      end
      ST_SWEEP: begin
        ctrl.sweep_wr = 1'b1;
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_RD_OUT: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("clearing pass not started after reset");

  a_strobe_from_read: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept && func == FUNC_READ))
    else $error("result beat without a read command");

  a_noeffect_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && func != FUNC_READ && color_mode == MODE_NONE) |=> !busy)
    else $error("no-effect command kept the block busy");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    ctrl.wr_back |-> $past(ctrl.rd_draw))
    else $error("write-back without a preceding read");

endmodule

>>> hw/rtl/pfl_datapath.sv
`timescale 1ns / 1ps

module pfl_datapath #(
  parameter int DISP_WIDTH  = pfl_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = pfl_pkg::DISP_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pfl_pkg::ctrl_t             ctrl,
  output pfl_pkg::stat_t             stat,
  input  logic [2:0]                 func,
  input  logic signed [7:0]          x_pos,
  input  logic signed [7:0]          y_pos,
  input  logic signed [7:0]          span_w,
  input  logic signed [7:0]          span_h,
  input  logic [1:0]                 color_mode,
  input  logic [pfl_pkg::ADDR_W-1:0] read_addr,
  output logic [7:0]                 read_byte
);
  import pfl_pkg::*;

  localparam int PAGE_COUNT = (DISP_HEIGHT + 7) / 8;
  localparam int COL_W = $clog2(DISP_WIDTH);
  localparam int PG_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(PAGE_COUNT * DISP_WIDTH - 1);
  localparam logic [ADDR_W-1:0] STORE_LAST = ADDR_W'(STORE_DEPTH - 1);
  localparam logic signed [9:0] W_S = 10'(DISP_WIDTH);
  localparam logic signed [9:0] H_S = 10'(DISP_HEIGHT);

  logic [7:0] mem [STORE_DEPTH];

  logic signed [9:0] xs, ys, wx, hy, xe, ye, c0, c1, r0, r1, c_end, r_end;

  logic [COL_W-1:0]  col, col_first, col_last;
  logic [PG_W-1:0]   page, page_top, page_bot;
  logic [2:0]        lo_top, hi_bot, lo, hi;
  logic [1:0]        mode;
  logic              empty;
  logic [7:0]        rdata, mask, new_byte, sweep_val, wdata;
  logic [ADDR_W-1:0] draw_addr, sweep_addr, sweep_last_addr, waddr;
  logic              we;

  always_comb begin
    xs = {{2{x_pos[7]}}, x_pos};
    ys = {{2{y_pos[7]}}, y_pos};
    wx = {{2{span_w[7]}}, span_w};
    hy = {{2{span_h[7]}}, span_h};
    xe = (func == FUNC_VLINE) ? xs + 10'sd1 : xs + wx;
    ye = (func == FUNC_HLINE) ? ys + 10'sd1 : ys + hy;
    c0 = (xs < 10'sd0) ? 10'sd0 : xs;
    c1 = (xe > W_S) ? W_S : xe;
    r0 = (ys < 10'sd0) ? 10'sd0 : ys;
    r1 = (ye > H_S) ? H_S : ye;
    c_end = c1 - 10'sd1;
    r_end = r1 - 10'sd1;
  end

  always_comb begin
    draw_addr = ADDR_W'(page) * ADDR_W'(DISP_WIDTH) + ADDR_W'(col);
    lo = (page == page_top) ? lo_top : 3'd0;
    hi = (page == page_bot) ? hi_bot : 3'd7;
    mask = (BYTE_ONES << lo) & (BYTE_ONES >> (3'd7 - hi));
    unique case (mode)
      MODE_CLEAR:  new_byte = rdata & ~mask;
      MODE_SET:    new_byte = rdata | mask;
      MODE_TOGGLE: new_byte = rdata ^ mask;
      default:     new_byte = rdata;
    endcase
    we    = ctrl.wr_back || ctrl.sweep_wr;
    waddr = ctrl.wr_back ? draw_addr : sweep_addr;
    wdata = ctrl.wr_back ? new_byte : sweep_val;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (ctrl.rd_draw) begin
      rdata <= mem[draw_addr];
    end else if (ctrl.rd_host) begin
      rdata <= mem[read_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_draw) begin
      empty     <= (c1 <= c0) || (r1 <= r0);
      col       <= c0[COL_W-1:0];
      col_first <= c0[COL_W-1:0];
      col_last  <= c_end[COL_W-1:0];
      page      <= r0[PG_W+2:3];
      page_top  <= r0[PG_W+2:3];
      page_bot  <= r_end[PG_W+2:3];
      lo_top    <= r0[2:0];
      hi_bot    <= r_end[2:0];
      mode      <= color_mode;
    end else if (ctrl.wr_back) begin
      if (col == col_last) begin
        col  <= col_first;
        page <= page + PG_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr      <= '0;
      sweep_last_addr <= STORE_LAST;
      sweep_val       <= BYTE_ZERO;
    end else if (ctrl.load_sweep) begin
      sweep_addr      <= '0;
      sweep_last_addr <= FILL_LAST;
      sweep_val       <= (color_mode == MODE_SET) ? BYTE_ONES : BYTE_ZERO;
    end else if (ctrl.sweep_wr) begin
      sweep_addr <= sweep_addr + ADDR_W'(1);
    end
  end

  assign stat.empty      = empty;
  assign stat.draw_last  = (col == col_last) && (page == page_bot);
  assign stat.sweep_last = (sweep_addr == sweep_last_addr);
  assign read_byte       = rdata;

endmodule

>>> hw/rtl/page_framebuffer_line_fill.sv
`timescale 1ns / 1ps
// channel   handshake          fields
// command   start & !busy      func x_pos y_pos span_w span_h color_mode read_addr
// result    strobe (1 cycle)   read_byte
//
// Read: the byte is registered at accept and strobed from ST_RD_OUT.
// Line/rectangle: ST_CHECK, then one read-modify-write per covered byte.
// Screen fill (clear/set): ST_SWEEP writes all ceil(DISP_HEIGHT/8)*DISP_WIDTH bytes.
// Reset starts a clearing pass over all 1024 bytes (busy high).
// The receiver cannot stall; a result beat is valid for its strobe cycle only.

module page_framebuffer_line_fill #(
  parameter int DISP_WIDTH  = pfl_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = pfl_pkg::DISP_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 func,
  input  logic signed [7:0]          x_pos,
  input  logic signed [7:0]          y_pos,
  input  logic signed [7:0]          span_w,
  input  logic signed [7:0]          span_h,
  input  logic [1:0]                 color_mode,
  input  logic [pfl_pkg::ADDR_W-1:0] read_addr,
  output logic                       strobe,
  output logic [7:0]                 read_byte
);
  import pfl_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  pfl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .color_mode (color_mode),
    .stat       (stat),
    .ctrl       (ctrl),
    .busy       (busy),
    .strobe     (strobe)
  );

  pfl_datapath #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .func       (func),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .span_w     (span_w),
    .span_h     (span_h),
    .color_mode (color_mode),
    .read_addr  (read_addr),
    .read_byte  (read_byte)
  );

endmodule
